>>> rtl/pvgfc_pkg.sv
// ----------------------------------------------------------------------------
// pvgfc_pkg
// Shared types and constants for the PCM volume / format conversion unit.
// ----------------------------------------------------------------------------
package pvgfc_pkg;

    localparam int unsigned MAX_CHANNELS = 4;
    localparam int unsigned GAIN_REGS    = 4;
    localparam int unsigned CH_LIMIT     =
        (MAX_CHANNELS < GAIN_REGS) ? MAX_CHANNELS : GAIN_REGS;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned CH_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IN_FORMAT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_FORMAT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH3      = 3'd6;

    localparam logic signed [31:0] GAIN_UNITY = 32'sd65536;
    localparam logic [2:0]         CH_COUNT_RESET = 3'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CH_W-1:0]            t_chan;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

    typedef enum logic [1:0] {
        FMT_S16 = 2'd0,
        FMT_S24 = 2'd1,
        FMT_S32 = 2'd2
    } t_fmt;

    // right shift applied to the product before rounding
    typedef enum logic [1:0] {
        SH_8  = 2'd0,
        SH_16 = 2'd1,
        SH_24 = 2'd2,
        SH_32 = 2'd3
    } t_shift;

    // sideband that travels with a sample down the pipe
    typedef struct packed {
        t_chan  ch;
        t_shift shift;
        t_fmt   ofmt;
    } t_tag;

    // unused code 3 behaves as S32
    function automatic t_fmt to_fmt(input logic [1:0] code);
        t_fmt f;
        case (code)
            2'd0:    f = FMT_S16;
            2'd1:    f = FMT_S24;
            default: f = FMT_S32;
        endcase
        return f;
    endfunction

    // in_frac + 16 - out_frac; S16 into S32 is pre-shifted by 8 and lands on 8
    function automatic t_shift shift_sel(input t_fmt fi, input t_fmt fo);
        t_shift s;
        case (fi)
            FMT_S16: s = (fo == FMT_S16) ? SH_16 : SH_8;
            FMT_S24: s = (fo == FMT_S16) ? SH_24 : ((fo == FMT_S24) ? SH_16 : SH_8);
            default: s = (fo == FMT_S16) ? SH_32 : ((fo == FMT_S24) ? SH_24 : SH_16);
        endcase
        return s;
    endfunction

endpackage

>>> rtl/pvgfc_if.sv
// ----------------------------------------------------------------------------
// pvgfc channel interfaces
// Valid/ready channels for samples in, results out and register writes.
// ----------------------------------------------------------------------------
interface pvgfc_in_if;
    import pvgfc_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface pvgfc_out_if;
    import pvgfc_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_out;
    t_chan   channel_index;

    modport source (output valid, output sample_out, output channel_index, input ready);
    modport sink   (input valid, input sample_out, input channel_index, output ready);
endinterface

interface pvgfc_cfg_if;
    import pvgfc_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/pcm_volume_gain_format_convert_unit.sv
// Stages: input, product and result registers; the second stage holds a
//   32x32 multiplier.
// Throughput: one sample per cycle while the output is not stalled.
// A stalled output lets the input take samples until all three stages are full.
// Reset (synchronous, active low) empties the pipe, zeroes the channel counter
//   and loads formats S16/S16, two channels and unity gains.
// ----------------------------------------------------------------------------
// pcm_volume_gain_format_convert_unit
// Per-channel Q16.16 gain with S16/S24/S32 format conversion, rounding and
// saturation.
// ----------------------------------------------------------------------------
module pcm_volume_gain_format_convert_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pvgfc_cfg_if.sink          i_cfg,
    pvgfc_in_if.sink           i_in,
    pvgfc_out_if.source        o_out
);
    import pvgfc_pkg::*;

    // configuration
    logic [1:0]       r_in_format;
    logic [1:0]       r_out_format;
    logic [2:0]       r_channel_count;
    logic signed [31:0] r_gain [GAIN_REGS];

    // channel counter
    t_chan            r_chan_cnt;
    t_chan            n_chan_cnt;
    logic [2:0]       w_eff_channels;

    // pipe
    logic             r_s1_vld;
    t_sample          r_s1_x;
    logic signed [31:0] r_s1_gain;
    t_tag             r_s1_tag;

    logic             r_s2_vld;
    logic signed [63:0] r_s2_prod;
    t_tag             r_s2_tag;

    logic             r_out_vld;
    t_sample          r_out_sample;
    t_chan            r_out_ch;

    logic             w_out_en;
    logic             w_s2_en;
    logic             w_s1_en;
    logic             w_in_xfer;

    t_fmt             w_ifmt;
    t_fmt             w_ofmt;
    t_sample          w_x;
    logic signed [63:0] w_rnd;
    logic signed [63:0] w_hi;
    logic signed [63:0] w_lo;
    t_sample          w_sat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_format     <= 2'(FMT_S16);
            r_out_format    <= 2'(FMT_S16);
            r_channel_count <= CH_COUNT_RESET;
            for (int i = 0; i < GAIN_REGS; i++) begin
                r_gain[i] <= GAIN_UNITY;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_IN_FORMAT:     r_in_format     <= i_cfg.data[1:0];
                REG_OUT_FORMAT:    r_out_format    <= i_cfg.data[1:0];
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg.data[2:0];
                REG_GAIN_CH0:      r_gain[0]       <= i_cfg.data;
                REG_GAIN_CH1:      r_gain[1]       <= i_cfg.data;
                REG_GAIN_CH2:      r_gain[2]       <= i_cfg.data;
                REG_GAIN_CH3:      r_gain[3]       <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its content moves on
    assign w_out_en  = !r_out_vld || o_out.ready;
    assign w_s2_en   = !r_s2_vld  || w_out_en;
    assign w_s1_en   = !r_s1_vld  || w_s2_en;
    assign i_in.ready = w_s1_en;
    assign w_in_xfer = i_in.valid && w_s1_en;

    // zero channels acts as one; clamp to the number of gain registers
    always_comb begin
        if (r_channel_count == 3'd0) begin
            w_eff_channels = 3'd1;
        end else if (r_channel_count > 3'(CH_LIMIT)) begin
            w_eff_channels = 3'(CH_LIMIT);
        end else begin
            w_eff_channels = r_channel_count;
        end
        if (({1'b0, r_chan_cnt} + 3'd1) >= w_eff_channels) begin
            n_chan_cnt = '0;
        end else begin
            n_chan_cnt = r_chan_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= '0;
        end else if (w_in_xfer) begin
            r_chan_cnt <= n_chan_cnt;
        end
    end

    // input decode: sign-extend the container, pre-shift S16 going to S32
    assign w_ifmt = to_fmt(r_in_format);
    assign w_ofmt = to_fmt(r_out_format);

    always_comb begin
        case (w_ifmt)
            FMT_S16: begin
                if (w_ofmt == FMT_S32) begin
                    w_x = {{8{i_in.sample_in[15]}}, i_in.sample_in[15:0], 8'h00};
                end else begin
                    w_x = {{16{i_in.sample_in[15]}}, i_in.sample_in[15:0]};
                end
            end
            FMT_S24: w_x = {{8{i_in.sample_in[23]}}, i_in.sample_in[23:0]};
            default: w_x = i_in.sample_in;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_en) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_x         <= w_x;
            r_s1_gain      <= r_gain[r_chan_cnt];
            r_s1_tag.ch    <= r_chan_cnt;
            r_s1_tag.shift <= shift_sel(w_ifmt, w_ofmt);
            r_s1_tag.ofmt  <= w_ofmt;
        end
    end

    // multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_en && r_s1_vld) begin
            r_s2_prod <= r_s1_x * r_s1_gain;
            r_s2_tag  <= r_s1_tag;
        end
    end

    // round half up: add half an LSB of the result, then floor shift
    always_comb begin
        case (r_s2_tag.shift)
            SH_8:  w_rnd = (r_s2_prod + 64'sd128) >>> 8;
            SH_16: w_rnd = (r_s2_prod + 64'sd32768) >>> 16;
            SH_24: w_rnd = (r_s2_prod + 64'sd8388608) >>> 24;
            SH_32: w_rnd = (r_s2_prod + 64'sd2147483648) >>> 32;
        endcase
        case (r_s2_tag.ofmt)
            FMT_S16: begin
                w_hi = 64'sd32767;
                w_lo = -64'sd32768;
            end
            FMT_S24: begin
                w_hi = 64'sd8388607;
                w_lo = -64'sd8388608;
            end
            default: begin
                w_hi = 64'sd2147483647;
                w_lo = -64'sd2147483648;
            end
        endcase
        if (w_rnd > w_hi) begin
            w_sat = w_hi[31:0];
        end else if (w_rnd < w_lo) begin
            w_sat = w_lo[31:0];
        end else begin
            w_sat = w_rnd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_en) begin
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && r_s2_vld) begin
            r_out_sample <= w_sat;
            r_out_ch     <= r_s2_tag.ch;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.sample_out    = r_out_sample;
    assign o_out.channel_index = r_out_ch;

endmodule

>>> rtl/pvgfc_checker.sv
// ----------------------------------------------------------------------------
// pvgfc_checker
// Port-level checks of the volume / format conversion unit, bound to the top.
// ----------------------------------------------------------------------------
module pvgfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_sample,
    input logic [1:0]  i_out_channel
);
    // three register stages can hold samples
    localparam logic [2:0] PIPE_DEPTH = 3'd3;

    logic       w_in_xfer;
    logic       w_out_xfer;
    logic [2:0] r_inflight;
    logic [2:0] n_inflight;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    always_comb begin
        n_inflight = r_inflight;
        if (w_in_xfer && !w_out_xfer) begin
            n_inflight = r_inflight + 3'd1;
        end else if (!w_in_xfer && w_out_xfer) begin
            n_inflight = r_inflight - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample) && $stable(i_out_channel))
        else $error("result changed while stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 3'd0)
        else $error("result without a sample in flight");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= PIPE_DEPTH)
        else $error("more samples taken than the pipe can hold");

endmodule

bind pcm_volume_gain_format_convert_unit pvgfc_checker u_pvgfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_sample  (o_out.sample_out),
    .i_out_channel (o_out.channel_index)
);

>>> test/pcm_volume_gain_format_convert_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_volume_gain_format_convert_unit_tb
// Drives interleaved PCM samples through the gain/format unit and checks each
// output transfer against a local fixed-point predictor. The predictor tracks
// the channel counter, the formats and the gains. Register settings change
// between phases, and both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module pcm_volume_gain_format_convert_unit_tb;
    import pvgfc_pkg::*;

    localparam int       PIPE_LAT    = 3;
    localparam int       CYCLE_LIMIT = 300000;
    localparam int       N_PHASES    = 20;
    localparam int       HOLD_CYCLES = 400;
    localparam int       PRINT_CAP   = 50;
    localparam t_cfg_idx REG_UNMAPPED   = 3'd7;
    localparam logic [1:0] FMT_CODE_SPARE = 2'd3;

    typedef struct {
        t_sample sample;
        t_chan   chan;
    } t_scaled;

    typedef enum {RX_FULL, RX_CHOPPY, RX_HEAVY} t_rx_mode;

    class gain_scoreboard;
        logic [1:0]  in_code;
        logic [1:0]  out_code;
        logic [2:0]  chan_count;
        logic [31:0] gain [4];
        t_chan       chan_ctr;
        t_scaled     scaled_q [$];
        logic [15:0] pairs_seen;
        int unsigned n_checked;
        int unsigned n_errors;
        int unsigned n_writes;

        function new();
            in_code    = FMT_S16;
            out_code   = FMT_S16;
            chan_count = CH_COUNT_RESET;
            foreach (gain[i]) gain[i] = GAIN_UNITY;
            chan_ctr   = '0;
            pairs_seen = '0;
            n_checked  = 0;
            n_errors   = 0;
            n_writes   = 0;
        endfunction

        function int unsigned frac_of(logic [1:0] code);
            case (code)
                FMT_S16: return 15;
                FMT_S24: return 23;
                default: return 31;
            endcase
        endfunction

        function void apply_write(t_cfg_idx idx, t_cfg_data d);
            n_writes++;
            case (idx)
                REG_IN_FORMAT:     in_code    = d[1:0];
                REG_OUT_FORMAT:    out_code   = d[1:0];
                REG_CHANNEL_COUNT: chan_count = d[2:0];
                REG_GAIN_CH0:      gain[0]    = d;
                REG_GAIN_CH1:      gain[1]    = d;
                REG_GAIN_CH2:      gain[2]    = d;
                REG_GAIN_CH3:      gain[3]    = d;
                default: ;
            endcase
        endfunction

        // scale one accepted sample and queue the result it must produce
        function void note_sample(t_sample raw);
            logic signed [63:0] x, g, p, r, hi, lo;
            int unsigned        ifrac, ofrac, sh, n_act, nxt;
            t_scaled            e;
            ifrac = frac_of(in_code);
            ofrac = frac_of(out_code);
            case (in_code)
                FMT_S16: x = {{48{raw[15]}}, raw[15:0]};
                FMT_S24: x = {{40{raw[23]}}, raw[23:0]};
                default: x = {{32{raw[31]}}, raw};
            endcase
            // S16 into S32 goes through a 24-bit view first
            if (ifrac == 15 && ofrac == 31) begin
                x = x <<< 8;
                ifrac = 23;
            end
            sh = ifrac + 16 - ofrac;
            g  = {{32{gain[chan_ctr][31]}}, gain[chan_ctr]};
            p  = x * g;
            r  = ((p >>> (sh - 1)) + 64'sd1) >>> 1;
            hi = (64'sd1 <<< ofrac) - 64'sd1;
            lo = -hi - 64'sd1;
            if (r > hi) r = hi;
            else if (r < lo) r = lo;
            e.sample = r[31:0];
            e.chan   = chan_ctr;
            scaled_q.push_back(e);
            pairs_seen[{out_code, in_code}] = 1'b1;

            n_act = (chan_count == 0) ? 1 : chan_count;
            if (n_act > CH_LIMIT) n_act = CH_LIMIT;
            nxt = int'(chan_ctr) + 1;
            chan_ctr = (nxt >= n_act) ? '0 : t_chan'(nxt);
        endfunction

        task report(string what);
            n_errors++;
            if (n_errors <= PRINT_CAP)
                $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task check_result(t_sample s, t_chan c);
            t_scaled e;
            if (scaled_q.size() == 0) begin
                report($sformatf("unexpected result sample=%h ch=%0d", s, c));
            end else begin
                e = scaled_q.pop_front();
                n_checked++;
                if (s !== e.sample)
                    report($sformatf("sample_out %h, predicted %h (ch %0d)", s, e.sample, e.chan));
                if (c !== e.chan)
                    report($sformatf("channel_index %0d, predicted %0d", c, e.chan));
            end
        endtask

        function int pending();
            return scaled_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pvgfc_cfg_if cfg_if ();
    pvgfc_in_if  in_if ();
    pvgfc_out_if out_if ();

    pcm_volume_gain_format_convert_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    gain_scoreboard sb;
    t_rx_mode       rx_mode;
    int unsigned    hold_req;
    int unsigned    cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    // output side: runs of ready and stall, plus a long hold-off on request
    initial begin
        int unsigned hold_left;
        int unsigned rx_run;
        logic        rx_state;
        hold_left = 0;
        rx_run    = 0;
        rx_state  = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (rx_mode == RX_FULL) begin
                out_if.ready <= 1'b1;
            end else begin
                if (rx_run == 0) begin
                    rx_state = ~rx_state;
                    if (rx_state)
                        rx_run = $urandom_range(1, (rx_mode == RX_HEAVY) ? 3 : 12);
                    else
                        rx_run = $urandom_range(1, (rx_mode == RX_HEAVY) ? 20 : 5);
                end
                rx_run--;
                out_if.ready <= rx_state;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.sample_out, out_if.channel_index);
    end

    task write_reg(input t_cfg_idx idx, input t_cfg_data d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.apply_write(idx, d);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // format and count fields carry random junk in the unused upper bits
    task set_formats(input logic [1:0] fi, input logic [1:0] fo, input logic [2:0] cc);
        t_cfg_data j;
        j = $urandom;
        write_reg(REG_IN_FORMAT, {j[31:2], fi});
        j = $urandom;
        write_reg(REG_OUT_FORMAT, {j[31:2], fo});
        j = $urandom;
        write_reg(REG_CHANNEL_COUNT, {j[31:3], cc});
    endtask

    task set_gains(input logic [31:0] g [4]);
        for (int i = 0; i < 4; i++)
            write_reg(t_cfg_idx'(REG_GAIN_CH0 + i), g[i]);
    endtask

    task send_sample(input t_sample x);
        in_if.valid     <= 1'b1;
        in_if.sample_in <= x;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_sample(x);
    endtask

    task idle_in(input int unsigned n);
        in_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    function t_sample pick_sample(input logic [1:0] fi);
        logic [31:0] keep, val, junk;
        case (fi)
            FMT_S16: keep = 32'h0000_FFFF;
            FMT_S24: keep = 32'h00FF_FFFF;
            default: keep = 32'hFFFF_FFFF;
        endcase
        junk = $urandom;
        case ($urandom_range(0, 9))
            0:       val = keep >> 1;
            1:       val = ~(keep >> 1);
            2:       val = 32'($urandom_range(0, 31)) - 32'd16;
            default: val = $urandom;
        endcase
        return (junk & ~keep) | (val & keep);
    endfunction

    function logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return $urandom;
            4:       return GAIN_UNITY;
            5:       return -GAIN_UNITY;
            default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] gset [4];
        logic [1:0]  fi, fo;
        logic [2:0]  cc;
        int unsigned n_items, burst;
        bit          stream;

        sb       = new();
        hold_req = 0;
        rx_mode  = RX_FULL;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.sample_in <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: S16 to S16, two channels, unity gain; upper bits ignored
        send_sample(32'h0000_7FFF);
        send_sample(32'hFFFF_8000);
        send_sample(32'hABCD_0001);
        send_sample(32'h0000_0000);
        drain();

        // S16 into S32 with full-scale gains saturates both ways
        gset = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'hFFFF_0000};
        set_gains(gset);
        set_formats(FMT_S16, FMT_S32, 3'd1);
        send_sample(32'h0000_7FFF);
        send_sample(32'h0000_8000);
        drain();

        // S24 to S24, four channels; half gain hits the rounding tie on +1 and -1
        set_formats(FMT_S24, FMT_S24, 3'd4);
        send_sample(32'h007F_FFFF);
        send_sample(32'hFF80_0000);
        send_sample(32'h0000_0001);
        send_sample(32'h1200_0003);
        send_sample(32'h0080_0000);
        send_sample(32'h0000_0001);
        send_sample(32'h00FF_FFFF);
        drain();

        // counter sits at 3; count 0 acts as 1 and spare format code acts as S32
        set_formats(FMT_CODE_SPARE, FMT_CODE_SPARE, 3'd0);
        write_reg(REG_UNMAPPED, $urandom);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0001);
        drain();

        // count above the limit clamps to four
        set_formats(FMT_S32, FMT_S16, 3'd7);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 16) begin
                fi = 2'(ph % 4);
                fo = 2'(ph / 4);
            end else begin
                fi = 2'($urandom_range(0, 3));
                fo = 2'($urandom_range(0, 3));
            end
            cc = 3'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(1, 4));
            foreach (gset[i]) gset[i] = pick_gain();
            set_gains(gset);
            set_formats(fi, fo, cc);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNMAPPED, $urandom);

            stream  = ($urandom_range(0, 3) == 0);
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            if (ph == 5) begin
                // output held off while input streams: pipe fills and backs up
                stream   = 1'b1;
                rx_mode  = RX_FULL;
                hold_req = HOLD_CYCLES;
            end
            n_items = $urandom_range(80, 120);
            burst   = $urandom_range(1, 24);
            for (int k = 0; k < n_items; k++) begin
                send_sample(pick_sample(fi));
                if (!stream) begin
                    burst--;
                    if (burst == 0) begin
                        idle_in($urandom_range(1, 8));
                        burst = $urandom_range(1, 24);
                    end
                end
            end
            drain();
        end

        $display("%0d samples checked over %0d of 16 format code pairings",
                 sb.n_checked, $countones(sb.pairs_seen));
        $display("%0d register writes, %0d random phases, one %0d-cycle output hold-off",
                 sb.n_writes, N_PHASES, HOLD_CYCLES);
        if (sb.n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
